// ===== hdl/hidrl_pkg.sv =====
`default_nettype none

package hidrl_pkg;

  // Parser position inside the item stream
  typedef enum logic [1:0] {
    PH_PREFIX    = 2'd0,
    PH_SHORT     = 2'd1,
    PH_LONG_SIZE = 2'd2,
    PH_LONG_SKIP = 2'd3
  } phase_e;

  localparam logic [7:0]  LONG_PREFIX      = 8'hFE;
  localparam logic [1:0]  SIZE_NONE        = 2'd0;
  localparam logic [1:0]  SIZE_FOUR        = 2'd3;
  localparam logic [1:0]  TYPE_MAIN        = 2'd0;
  localparam logic [1:0]  TYPE_GLOBAL      = 2'd1;
  localparam logic [3:0]  TAG_INPUT        = 4'h8;
  localparam logic [3:0]  TAG_REPORT_SIZE  = 4'h7;
  localparam logic [3:0]  TAG_REPORT_ID    = 4'h8;
  localparam logic [3:0]  TAG_REPORT_COUNT = 4'h9;
  localparam logic [29:0] LEN_MAX          = 30'h3FFF_FFFF;
  localparam logic [29:0] DEFAULT_LEN      = 30'd8;

  // Snapshot handed from the parser to the finish stage on the last beat
  typedef struct packed {
    logic        valid;
    logic        id_used;
    logic [29:0] max_len;
  } fin_t;

  // Close a report: round bits up to bytes, add the ID byte, fold into the max
  function automatic logic [29:0] close_max(input logic [63:0] bits,
                                            input logic        id_used,
                                            input logic [29:0] cur_max);
    logic [61:0] len;
    logic [29:0] len_sat;
    logic [29:0] res;
    len     = 62'(bits[63:3]) + 62'(|bits[2:0]) + 62'(id_used);
    len_sat = (len > 62'(LEN_MAX)) ? LEN_MAX : len[29:0];
    res     = cur_max;
    if ((bits != 64'd0) && (len_sat > cur_max)) begin
      res = len_sat;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hid_input_report_length_parser.sv =====
// Longest input report length from a HID report descriptor.
// Input channel: one descriptor byte per beat on desc_byte_i with last_byte_i
// marking the final byte; a beat moves when in_valid_i is high and in_stall_o
// is low. Output channel: one report_bytes_o beat per descriptor, moving when
// out_valid_o is high and out_stall_i is low.
// Throughput: one byte per cycle while no last byte waits; a byte is decoded
// in a single pass, and size * count is kept in a register so an Input item
// only needs one add. A result passes the input register, item decode into
// the finish snapshot, close and output register.
// A new descriptor may start right behind the last byte of the previous one.
// While the output is stalled, ordinary bytes are still taken; one result
// waits in the output register and one more in the finish snapshot. A last
// byte that finds both full waits, and in_stall_o rises once that byte sits
// in the input register.
// Reset clears the parser, the stored globals and both handshakes; no
// result is pending after reset.
`default_nettype none

module hid_input_report_length_parser #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  desc_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [29:0]      report_bytes_o
);

  hidrl_pkg::fin_t      fin;
  logic [ACC_WIDTH-1:0] fin_bits;
  logic                 fin_take;

  hidrl_parse #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .desc_byte_i (desc_byte_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .fin_take_i  (fin_take),
    .fin_o       (fin),
    .fin_bits_o  (fin_bits)
  );

  hidrl_finish #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fin_i          (fin),
    .fin_bits_i     (fin_bits),
    .fin_take_o     (fin_take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_bytes_o (report_bytes_o)
  );

endmodule

`default_nettype wire

// ===== hdl/hidrl_parse.sv =====
`default_nettype none

module hidrl_parse #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [7:0]           desc_byte_i,
  input  wire logic                 last_byte_i,
  output logic                      in_stall_o,
  input  wire logic                 fin_take_i,
  output hidrl_pkg::fin_t           fin_o,
  output logic [ACC_WIDTH-1:0]      fin_bits_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state
  hidrl_pkg::phase_e    phase_q, phase_d;
  logic [8:0]           bl_q, bl_d;
  logic [7:0]           hdr_q, hdr_d;
  logic [31:0]          val_q, val_d;
  logic [1:0]           idx_q, idx_d;
  logic [31:0]          size_q, size_d;
  logic [31:0]          count_q, count_d;
  logic                 ids_q, ids_d;
  logic                 idnz_q, idnz_d;
  logic [ACC_WIDTH-1:0] bt_q, bt_d;
  logic [29:0]          max_q, max_d;
  logic [ACC_WIDTH-1:0] prod_q, prod_d;

  // Finish snapshot
  logic                 fin_valid_q;
  logic                 fin_id_q;
  logic [29:0]          fin_max_q;
  logic [ACC_WIDTH-1:0] fin_bits_q;

  logic        fin_ready;
  logic        parse_fire;
  logic        in_ready;
  logic        run;
  logic [7:0]  run_hdr;
  logic [31:0] run_val;
  logic [31:0] val_new;
  logic        is_size;
  logic        is_count;
  logic        is_id;
  logic        is_input;
  logic [63:0] prod_full;
  logic        prod_sat;
  logic [ACC_WIDTH:0] sum;

  assign fin_ready  = !fin_valid_q || fin_take_i;
  assign parse_fire = in_valid_q && (!in_last_q || fin_ready);
  assign in_ready   = !in_valid_q || parse_fire;
  assign in_stall_o = !in_ready;

  // Item framing
  always_comb begin
    phase_d = phase_q;
    bl_d    = bl_q;
    hdr_d   = hdr_q;
    val_d   = val_q;
    idx_d   = idx_q;
    run     = 1'b0;
    run_hdr = hdr_q;
    val_new = val_q | (32'(in_byte_q) << {idx_q, 3'b000});
    run_val = val_new;
    unique case (phase_q)
      hidrl_pkg::PH_PREFIX: begin
        if (in_byte_q == hidrl_pkg::LONG_PREFIX) begin
          phase_d = hidrl_pkg::PH_LONG_SIZE;
        end else begin
          hdr_d   = in_byte_q;
          val_d   = '0;
          idx_d   = '0;
          run_hdr = in_byte_q;
          run_val = '0;
          if (in_byte_q[1:0] == hidrl_pkg::SIZE_NONE) begin
            run = 1'b1;
          end else begin
            bl_d    = (in_byte_q[1:0] == hidrl_pkg::SIZE_FOUR) ? 9'd4 : 9'(in_byte_q[1:0]);
            phase_d = hidrl_pkg::PH_SHORT;
          end
        end
      end
      hidrl_pkg::PH_SHORT: begin
        val_d = val_new;
        idx_d = idx_q + 2'd1;
        if (bl_q <= 9'd1) begin
          bl_d    = '0;
          phase_d = hidrl_pkg::PH_PREFIX;
          run     = 1'b1;
        end else begin
          bl_d = bl_q - 9'd1;
        end
      end
      hidrl_pkg::PH_LONG_SIZE: begin
        bl_d    = 9'(in_byte_q) + 9'd1;
        phase_d = hidrl_pkg::PH_LONG_SKIP;
      end
      hidrl_pkg::PH_LONG_SKIP: begin
        if (bl_q <= 9'd1) begin
          bl_d    = '0;
          phase_d = hidrl_pkg::PH_PREFIX;
        end else begin
          bl_d = bl_q - 9'd1;
        end
      end
      default: phase_d = hidrl_pkg::PH_PREFIX;
    endcase
  end

  // Item execution
  assign is_size  = run && (run_hdr[3:2] == hidrl_pkg::TYPE_GLOBAL)
                        && (run_hdr[7:4] == hidrl_pkg::TAG_REPORT_SIZE);
  assign is_count = run && (run_hdr[3:2] == hidrl_pkg::TYPE_GLOBAL)
                        && (run_hdr[7:4] == hidrl_pkg::TAG_REPORT_COUNT);
  assign is_id    = run && (run_hdr[3:2] == hidrl_pkg::TYPE_GLOBAL)
                        && (run_hdr[7:4] == hidrl_pkg::TAG_REPORT_ID);
  assign is_input = run && (run_hdr[3:2] == hidrl_pkg::TYPE_MAIN)
                        && (run_hdr[7:4] == hidrl_pkg::TAG_INPUT);

  assign size_d  = is_size  ? run_val : size_q;
  assign count_d = is_count ? run_val : count_q;

  // Keep size * count ready for the next Input item
  assign prod_full = size_d * count_d;
  assign prod_sat  = (({1'b0, prod_full} >> ACC_WIDTH) != 65'd0);
  assign prod_d    = prod_sat ? '1 : prod_full[ACC_WIDTH-1:0];

  assign sum = {1'b0, bt_q} + {1'b0, prod_q};

  always_comb begin
    bt_d   = bt_q;
    max_d  = max_q;
    ids_d  = ids_q;
    idnz_d = idnz_q;
    if (is_id) begin
      max_d  = hidrl_pkg::close_max(64'(bt_q), ids_q || idnz_q, max_q);
      ids_d  = 1'b1;
      idnz_d = (run_val != 32'd0);
      bt_d   = '0;
    end else if (is_input) begin
      bt_d = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      phase_q     <= hidrl_pkg::PH_PREFIX;
      bl_q        <= '0;
      hdr_q       <= '0;
      val_q       <= '0;
      idx_q       <= '0;
      size_q      <= '0;
      count_q     <= '0;
      ids_q       <= 1'b0;
      idnz_q      <= 1'b0;
      bt_q        <= '0;
      max_q       <= '0;
      prod_q      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (fin_take_i) begin
        fin_valid_q <= 1'b0;
      end
      if (parse_fire) begin
        if (in_last_q) begin
          // Hand off the snapshot, then start the next descriptor clean
          fin_valid_q <= 1'b1;
          phase_q     <= hidrl_pkg::PH_PREFIX;
          bl_q        <= '0;
          hdr_q       <= '0;
          val_q       <= '0;
          idx_q       <= '0;
          size_q      <= '0;
          count_q     <= '0;
          ids_q       <= 1'b0;
          idnz_q      <= 1'b0;
          bt_q        <= '0;
          max_q       <= '0;
          prod_q      <= '0;
        end else begin
          phase_q <= phase_d;
          bl_q    <= bl_d;
          hdr_q   <= hdr_d;
          val_q   <= val_d;
          idx_q   <= idx_d;
          size_q  <= size_d;
          count_q <= count_d;
          ids_q   <= ids_d;
          idnz_q  <= idnz_d;
          bt_q    <= bt_d;
          max_q   <= max_d;
          prod_q  <= prod_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_byte_q <= desc_byte_i;
      in_last_q <= last_byte_i;
    end
    if (parse_fire && in_last_q) begin
      fin_id_q   <= ids_d || idnz_d;
      fin_max_q  <= max_d;
      fin_bits_q <= bt_d;
    end
  end

  assign fin_o.valid   = fin_valid_q;
  assign fin_o.id_used = fin_id_q;
  assign fin_o.max_len = fin_max_q;
  assign fin_bits_o    = fin_bits_q;

`ifndef SYNTHESIS
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !fin_take_i |=> fin_valid_q)
    else $error("finish snapshot dropped before it was taken");

  a_short_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hidrl_pkg::PH_SHORT) |-> (bl_q != 9'd0) && (bl_q <= 9'd4))
    else $error("short item byte count out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_fire && in_last_q |=> (phase_q == hidrl_pkg::PH_PREFIX) && (bt_q == '0)
                                && (max_q == '0) && !ids_q)
    else $error("parser state not cleared after last beat");
`endif

endmodule

`default_nettype wire

// ===== hdl/hidrl_finish.sv =====
`default_nettype none

module hidrl_finish #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hidrl_pkg::fin_t      fin_i,
  input  wire logic [ACC_WIDTH-1:0] fin_bits_i,
  output logic                      fin_take_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [29:0]               report_bytes_o
);

  logic        out_valid_q;
  logic [29:0] report_q;
  logic        out_ready;
  logic [29:0] close_len;
  logic [29:0] report_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fin_take_o = fin_i.valid && out_ready;

  // Close the open report, then fall back to the default when nothing counted
  assign close_len = hidrl_pkg::close_max(64'(fin_bits_i), fin_i.id_used, fin_i.max_len);
  assign report_d  = (close_len == 30'd0) ? hidrl_pkg::DEFAULT_LEN : close_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take_o) begin
      report_q <= report_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_bytes_o = report_q;

`ifndef SYNTHESIS
  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take_o |=> out_valid_q)
    else $error("taken snapshot did not reach the output");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (report_q != 30'd0))
    else $error("zero report length presented");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(report_q))
    else $error("stalled result changed before it was taken");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int ACC_WIDTH = 32;

  localparam logic [1:0] SIZE_ONE = 2'd1;
  localparam logic [1:0] SIZE_TWO = 2'd2;

  // Item prefixes with the size code left at zero
  localparam logic [7:0] BASE_SIZE  = {hidrl_pkg::TAG_REPORT_SIZE, hidrl_pkg::TYPE_GLOBAL,
                                       hidrl_pkg::SIZE_NONE};
  localparam logic [7:0] BASE_COUNT = {hidrl_pkg::TAG_REPORT_COUNT, hidrl_pkg::TYPE_GLOBAL,
                                       hidrl_pkg::SIZE_NONE};
  localparam logic [7:0] BASE_ID    = {hidrl_pkg::TAG_REPORT_ID, hidrl_pkg::TYPE_GLOBAL,
                                       hidrl_pkg::SIZE_NONE};
  localparam logic [7:0] BASE_INPUT = {hidrl_pkg::TAG_INPUT, hidrl_pkg::TYPE_MAIN,
                                       hidrl_pkg::SIZE_NONE};

  typedef struct {
    logic [7:0] data;
    logic       last;
  } beat_t;

  class report_length_scoreboard #(int ACC_W = 32);
    hidrl_pkg::phase_e phase;
    logic [8:0]  left;
    logic [7:0]  header;
    logic [31:0] value;
    logic [1:0]  idx;
    logic [31:0] size_bits;
    logic [31:0] count;
    bit          ids_used;
    bit          id_nz;
    logic [63:0] bits;
    logic [29:0] longest;
    logic [29:0] length_q[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase     = hidrl_pkg::PH_PREFIX;
      left      = '0;
      header    = '0;
      value     = '0;
      idx       = '0;
      size_bits = '0;
      count     = '0;
      ids_used  = 1'b0;
      id_nz     = 1'b0;
      bits      = '0;
      longest   = '0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return length_q.size();
    endfunction

    function void close_report();
      logic [63:0] len;
      if (bits != 64'd0) begin
        len = (bits >> 3) + 64'(|bits[2:0]) + 64'(ids_used || id_nz);
        if (len > 64'(hidrl_pkg::LEN_MAX)) len = 64'(hidrl_pkg::LEN_MAX);
        if (len[29:0] > longest) longest = len[29:0];
      end
    endfunction

    function void run_item();
      logic [63:0] acc_max;
      logic [63:0] prod;
      acc_max = {64{1'b1}} >> (64 - ACC_W);
      if (header[3:2] == hidrl_pkg::TYPE_GLOBAL) begin
        if (header[7:4] == hidrl_pkg::TAG_REPORT_SIZE) begin
          size_bits = value;
        end else if (header[7:4] == hidrl_pkg::TAG_REPORT_COUNT) begin
          count = value;
        end else if (header[7:4] == hidrl_pkg::TAG_REPORT_ID) begin
          // close first, the ID byte of this item only counts for later reports
          close_report();
          id_nz    = (value != 32'd0);
          ids_used = 1'b1;
          bits     = '0;
        end
      end else if (header[3:2] == hidrl_pkg::TYPE_MAIN &&
                   header[7:4] == hidrl_pkg::TAG_INPUT) begin
        prod = 64'(size_bits) * 64'(count);
        if (prod > acc_max - bits) bits = acc_max;
        else bits = bits + prod;
      end
    endfunction

    function void note_beat(logic [7:0] b, logic last);
      logic [2:0] n;
      case (phase)
        hidrl_pkg::PH_PREFIX: begin
          if (b == hidrl_pkg::LONG_PREFIX) begin
            phase = hidrl_pkg::PH_LONG_SIZE;
          end else begin
            n      = (b[1:0] == hidrl_pkg::SIZE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
            header = b;
            value  = '0;
            idx    = '0;
            if (n == 3'd0) begin
              run_item();
            end else begin
              left  = 9'(n);
              phase = hidrl_pkg::PH_SHORT;
            end
          end
        end
        hidrl_pkg::PH_SHORT: begin
          value = value | (32'(b) << {idx, 3'b000});
          idx   = idx + 2'd1;
          if (left <= 9'd1) begin
            left  = '0;
            phase = hidrl_pkg::PH_PREFIX;
            run_item();
          end else begin
            left = left - 9'd1;
          end
        end
        hidrl_pkg::PH_LONG_SIZE: begin
          // skip count is the tag byte plus the data bytes named by the size byte
          left  = 9'(b) + 9'd1;
          phase = hidrl_pkg::PH_LONG_SKIP;
        end
        default: begin
          if (left <= 9'd1) begin
            left  = '0;
            phase = hidrl_pkg::PH_PREFIX;
          end else begin
            left = left - 9'd1;
          end
        end
      endcase
      if (last) begin
        close_report();
        length_q = {length_q, ((longest != 30'd0) ? longest : hidrl_pkg::DEFAULT_LEN)};
        clear();
      end
    endfunction

    task check_result(logic [29:0] got);
      logic [29:0] want;
      if (length_q.size() == 0) begin
        report($sformatf("report_bytes %0d with no descriptor pending", got));
      end else begin
        want = length_q.pop_front();
        if (got !== want) report($sformatf("report_bytes %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  desc_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [29:0] report_bytes_o;

  report_length_scoreboard #(ACC_WIDTH) sb;
  beat_t beat_q[$];
  int    src_idle_pct   = 0;
  int    sink_stall_pct = 0;
  int    hold_request   = 0;
  int    hold_cnt       = 0;

  hid_input_report_length_parser #(
    .ACC_WIDTH(ACC_WIDTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .desc_byte_i    (desc_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_bytes_o (report_bytes_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_beat(desc_byte_i, last_byte_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(report_bytes_o);
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_cnt     = hold_request;
        hold_request = 0;
      end
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    beat_t t;
    t.data = b;
    t.last = 1'b0;
    beat_q = {beat_q, t};
  endfunction

  function automatic void add_item(logic [7:0] base, logic [31:0] v, logic [1:0] code);
    int n;
    n = (code == hidrl_pkg::SIZE_FOUR) ? 4 : int'(code);
    add_byte(base | 8'(code));
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void add_sized(logic [7:0] base, logic [31:0] v);
    logic [1:0] code;
    if (v == 32'd0) code = hidrl_pkg::SIZE_NONE;
    else if (v < 32'd256) code = SIZE_ONE;
    else if (v < 32'd65536) code = SIZE_TWO;
    else code = hidrl_pkg::SIZE_FOUR;
    if ($urandom_range(3) == 0) code = hidrl_pkg::SIZE_FOUR;
    add_item(base, v, code);
  endfunction

  function automatic void add_long(int s);
    add_byte(hidrl_pkg::LONG_PREFIX);
    add_byte(8'(s));
    add_byte(8'($urandom));
    for (int i = 0; i < s; i++) add_byte(8'($urandom));
  endfunction

  function automatic void end_descriptor();
    beat_t t;
    t      = beat_q[beat_q.size() - 1];
    t.last = 1'b1;
    beat_q[beat_q.size() - 1] = t;
  endfunction

  function automatic void add_random_descriptor(int max_items);
    int          n_items;
    int          pick;
    int          start;
    int          s;
    logic [31:0] v;
    logic [7:0]  b;
    start   = beat_q.size();
    n_items = $urandom_range(max_items, 0);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        v = ($urandom_range(19) == 0) ? $urandom : $urandom_range(16, 1);
        add_sized(BASE_SIZE, v);
      end else if (pick < 36) begin
        v = ($urandom_range(19) == 0) ? $urandom : $urandom_range(8, 0);
        if ($urandom_range(9) == 0) v = $urandom_range(255);
        add_sized(BASE_COUNT, v);
      end else if (pick < 56) begin
        add_item(BASE_INPUT, $urandom, 2'($urandom_range(2)));
      end else if (pick < 66) begin
        add_item(BASE_ID, $urandom_range(3), 2'($urandom));
      end else if (pick < 78) begin
        b = 8'($urandom);
        if (b == hidrl_pkg::LONG_PREFIX) b = 8'h00;
        add_item({b[7:2], hidrl_pkg::SIZE_NONE}, $urandom, b[1:0]);
      end else if (pick < 86) begin
        add_long(($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(4));
      end else begin
        add_byte(8'($urandom));
      end
    end
    // cut an item off at the end of the stream now and then
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: begin
          b = {6'($urandom), 2'($urandom_range(3, 1))};
          if (b == hidrl_pkg::LONG_PREFIX) b = BASE_SIZE | 8'(SIZE_TWO);
          add_byte(b);
          s = (b[1:0] == hidrl_pkg::SIZE_FOUR) ? 4 : int'(b[1:0]);
          s = $urandom_range(s - 1, 0);
          for (int i = 0; i < s; i++) add_byte(8'($urandom));
        end
        1: add_byte(hidrl_pkg::LONG_PREFIX);
        2: begin
          add_byte(hidrl_pkg::LONG_PREFIX);
          add_byte(8'($urandom));
        end
        default: begin
          s = $urandom_range(6, 1);
          add_byte(hidrl_pkg::LONG_PREFIX);
          add_byte(8'(s));
          add_byte(8'($urandom));
          s = $urandom_range(s - 1, 0);
          for (int i = 0; i < s; i++) add_byte(8'($urandom));
        end
      endcase
    end
    if (beat_q.size() == start) add_byte(8'($urandom));
    end_descriptor();
  endfunction

  task automatic send_beat(beat_t bt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    desc_byte_i <= bt.data;
    last_byte_i <= bt.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_queued();
    while (beat_q.size() != 0) send_beat(beat_q.pop_front());
  endtask

  task automatic run_phase(int n_bytes, int idle, int stall, int max_items);
    while (beat_q.size() < n_bytes) add_random_descriptor(max_items);
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    send_queued();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty report falls back to the default length
    add_byte(8'h00);
    end_descriptor();
    // saturated totals, with and without the ID byte
    add_item(BASE_SIZE, '1, hidrl_pkg::SIZE_FOUR);
    add_item(BASE_COUNT, '1, hidrl_pkg::SIZE_FOUR);
    add_item(BASE_INPUT, '0, hidrl_pkg::SIZE_NONE);
    add_item(BASE_ID, '0, hidrl_pkg::SIZE_NONE);
    add_item(BASE_INPUT, '0, hidrl_pkg::SIZE_NONE);
    end_descriptor();
    // empty long item, plain report, then a short item cut off by the end
    add_byte(hidrl_pkg::LONG_PREFIX);
    add_byte(8'h00);
    add_byte(8'h00);
    add_item(BASE_SIZE, 32'd8, SIZE_ONE);
    add_item(BASE_COUNT, 32'd3, SIZE_ONE);
    add_item(BASE_INPUT, 32'd2, SIZE_ONE);
    add_byte(BASE_SIZE | 8'(SIZE_TWO));
    add_byte(8'h01);
    end_descriptor();
    send_queued();

    run_phase(240, 0, 0, 12);
    run_phase(240, 82, 0, 12);
    run_phase(240, 0, 82, 12);
    run_phase(240, 29, 29, 12);
    // hold the output off while short descriptors keep coming
    hold_request = 400;
    run_phase(150, 0, 0, 2);
    run_phase(100, 0, 0, 12);
    in_valid_i <= 1'b0;

    sink_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
